[rtl/text_line_to_char_lcd_writer_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef TEXT_LINE_TO_CHAR_LCD_WRITER_MACROS_SVH
`define TEXT_LINE_TO_CHAR_LCD_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlcd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlcd check failed");

`endif

[rtl/tlcd_pkg.sv]
package tlcd_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ROW = 2'd1;

  // Register reset values.
  localparam logic [7:0] END_BYTE_RESET   = 8'h0A;
  localparam logic [6:0] SECOND_ROW_RESET = 7'h40;

  // Display commands.
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // Number of display jobs the queue between front and back can hold.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One bus write toward the display.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } tlcd_write_t;

endpackage

[rtl/text_line_to_char_lcd_writer.sv]
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  rx_byte_i
// output    out        out_valid_o / out_stall_i is_data_o, bus_byte_o, last_o
// config    in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// An ordinary byte is written to the line store, or dropped with the fill count
// restarted when the store is full. The end byte starts a run of 3 writes plus
// the smaller of 2*ROW_CHARS and BUFFER_DEPTH-1 characters at most (34 with the
// defaults), one per cycle while out_stall_i is low, apart from queue, pop and
// row-switch steps; the run sequencer and two-port line store set that pace.
// Input is stalled from the end byte until the run's last write is registered.
// Reset clears the fill count, the queue, the sequencer and the registers to
// their defaults; the line store is not cleared.
module text_line_to_char_lcd_writer #(
  parameter int unsigned BUFFER_DEPTH = 32,
  parameter int unsigned ROW_CHARS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_data_o,
  output logic [7:0]                       bus_byte_o,
  output logic                             last_o,
  input  logic                             cfg_we_i,
  input  logic [tlcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tlcd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [7:0]            end_byte_q;
  logic [6:0]            second_row_q;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [7:0]            ram_wdata;
  logic [AW-1:0]         raddr0;
  logic [AW-1:0]         raddr1;
  logic [7:0]            rdata0;
  logic [7:0]            rdata1;
  logic                  job_push;
  logic [AW-1:0]         job_fill_in;
  logic [AW-1:0]         job_fill_out;
  logic                  job_full;
  logic                  job_empty;
  logic                  job_pop;
  logic                  back_busy;
  logic                  hold;
  tlcd_pkg::tlcd_write_t out_write;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q   <= tlcd_pkg::END_BYTE_RESET;
      second_row_q <= tlcd_pkg::SECOND_ROW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlcd_pkg::REG_END_BYTE:   end_byte_q   <= cfg_data_i;
        tlcd_pkg::REG_SECOND_ROW: second_row_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Hold off new bytes while a display job is queued or running.
  assign hold = job_full || !job_empty || back_busy;

  tlcd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .end_byte_i  (end_byte_q),
    .hold_i      (hold),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_fill_o  (job_fill_in)
  );

  tlcd_line_ram #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  tlcd_job_fifo #(
    .WIDTH(AW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_fill_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_fill_out)
  );

  tlcd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .ROW_CHARS   (ROW_CHARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!job_empty),
    .job_fill_i   (job_fill_out),
    .job_pop_o    (job_pop),
    .second_row_i (second_row_q),
    .raddr0_o     (raddr0),
    .raddr1_o     (raddr1),
    .rdata0_i     (rdata0),
    .rdata1_i     (rdata1),
    .busy_o       (back_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_write)
  );

  assign is_data_o  = out_write.is_data;
  assign bus_byte_o = out_write.bus_byte;
  assign last_o     = out_write.last;

endmodule

[rtl/tlcd_line_ram.sv]
module tlcd_line_ram #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [7:0]               rdata0_o,
  output logic [7:0]               rdata1_o
);

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned ENTRIES = 2 ** AW;

  logic [7:0] mem_q [ENTRIES];
  logic [7:0] rdata0_q;
  logic [7:0] rdata1_q;

  // One write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

[rtl/tlcd_front.sv]
module tlcd_front #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic [7:0]                      end_byte_i,
  input  logic                            hold_i,
  output logic                            ram_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic                            job_push_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] job_fill_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] FILL_LAST = AW'(BUFFER_DEPTH - 1);

  logic [AW-1:0] fill_q;
  logic [AW-1:0] fill_d;
  logic          accept;
  logic          is_end;

  // The line store must not change while a display run reads it.
  assign in_stall_o = hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_end     = (rx_byte_i == end_byte_i);

  // Classify the byte: store it, drop it on overflow, or hand off a display job.
  always_comb begin
    fill_d     = fill_q;
    ram_we_o   = 1'b0;
    job_push_o = 1'b0;
    if (accept) begin
      if (is_end) begin
        job_push_o = 1'b1;
        fill_d     = '0;
      end else if (fill_q < FILL_LAST) begin
        ram_we_o = 1'b1;
        fill_d   = fill_q + 1'b1;
      end else begin
        fill_d = '0;
      end
    end
  end

  assign ram_waddr_o = fill_q;
  assign ram_wdata_o = rx_byte_i;
  assign job_fill_o  = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

[rtl/tlcd_job_fifo.sv]
module tlcd_job_fifo #(
  parameter int unsigned WIDTH = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (tlcd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(tlcd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(tlcd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tlcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tlcd_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_q [tlcd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/tlcd_back.sv]
module tlcd_back #(
  parameter int unsigned BUFFER_DEPTH = 32,
  parameter int unsigned ROW_CHARS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] job_fill_i,
  output logic                            job_pop_o,
  input  logic [6:0]                      second_row_i,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr0_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr1_o,
  input  logic [7:0]                      rdata0_i,
  input  logic [7:0]                      rdata1_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tlcd_pkg::tlcd_write_t           out_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  // Position counter reaches one past the end of the bottom row, plus lookahead.
  localparam int unsigned PW = $clog2(2 * ROW_CHARS + 2);
  localparam int unsigned CW = (PW > AW) ? PW : AW;
  localparam logic [PW-1:0] ROW_END  = PW'(ROW_CHARS);
  localparam logic [PW-1:0] LINE_END = PW'(2 * ROW_CHARS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_TOP_ADDR,
    S_TOP_ROW,
    S_BOT_ADDR,
    S_BOT_ROW
  } state_e;

  state_e                state_q, state_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         fill_q, fill_d;
  logic                  out_valid_q, out_valid_d;
  tlcd_pkg::tlcd_write_t out_q, out_d;

  logic [PW-1:0] pos_next;
  logic [PW-1:0] pos_d_next;
  logic [CW-1:0] fill_ext;
  logic          cur_in;
  logic          nxt_in;
  logic          top_ok;
  logic          bot_ok;
  logic          nxt_bot_ok;
  logic          load;

  // Character checks for the current position and the one after it.
  assign pos_next   = pos_q + 1'b1;
  assign fill_ext   = CW'(fill_q);
  assign cur_in     = CW'(pos_q) < fill_ext;
  assign nxt_in     = CW'(pos_next) < fill_ext;
  assign top_ok     = cur_in && (pos_q < ROW_END) && (rdata0_i != '0);
  assign bot_ok     = cur_in && (pos_q < LINE_END) && (rdata0_i != '0);
  assign nxt_bot_ok = nxt_in && (pos_next < LINE_END) && (rdata1_i != '0);

  // The output register can take a new write when empty or being drained.
  assign load = !out_valid_q || !out_stall_i;

  // Sequencer for one display run.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    out_d     = out_q;
    job_pop_o = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        pos_d = '0;
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          fill_d    = job_fill_i;
          state_d   = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_d       = '{is_data: 1'b0, bus_byte: tlcd_pkg::CMD_CLEAR, last: 1'b0};
          state_d     = S_TOP_ADDR;
        end
      end
      S_TOP_ADDR: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_d       = '{is_data: 1'b0, bus_byte: tlcd_pkg::CMD_SET_ADDR, last: 1'b0};
          state_d     = S_TOP_ROW;
        end
      end
      S_TOP_ROW: begin
        if (top_ok) begin
          if (load) begin
            out_valid_d = 1'b1;
            out_d       = '{is_data: 1'b1, bus_byte: rdata0_i, last: 1'b0};
            pos_d       = pos_next;
          end
        end else begin
          // Move the read position to the bottom row before its address write.
          pos_d   = ROW_END;
          state_d = S_BOT_ADDR;
        end
      end
      S_BOT_ADDR: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_d       = '{is_data:  1'b0,
                          bus_byte: tlcd_pkg::CMD_SET_ADDR | {1'b0, second_row_i},
                          last:     !bot_ok};
          state_d     = bot_ok ? S_BOT_ROW : S_IDLE;
        end
      end
      S_BOT_ROW: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_d       = '{is_data: 1'b1, bus_byte: rdata0_i, last: !nxt_bot_ok};
          pos_d       = pos_next;
          if (!nxt_bot_ok) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Read addresses follow the next position so the data lines up with pos_q.
  assign pos_d_next = pos_d + 1'b1;
  assign raddr0_o   = AW'(pos_d);
  assign raddr1_o   = AW'(pos_d_next);

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

[rtl/tlcd_checker.sv]
`include "text_line_to_char_lcd_writer_macros.svh"

module tlcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       is_data_o,
  input logic [7:0] bus_byte_o,
  input logic       last_o
);

  logic       run_open_q;
  logic       out_wait;
  logic       out_more;
  logic       run_first;
  logic       last_cmd;
  logic       is_clear_cmd;
  logic       is_addr_cmd;
  logic [9:0] out_word;

  // Terms shared by the checks below.
  assign out_wait     = out_valid_o && out_stall_i;
  assign out_more     = out_valid_o && !last_o;
  assign run_first    = out_valid_o && !run_open_q;
  assign last_cmd     = out_valid_o && last_o && !is_data_o;
  assign out_word     = {is_data_o, bus_byte_o, last_o};
  assign is_clear_cmd = !is_data_o && (bus_byte_o == tlcd_pkg::CMD_CLEAR) && !last_o;
  assign is_addr_cmd  = (bus_byte_o & tlcd_pkg::CMD_SET_ADDR) == tlcd_pkg::CMD_SET_ADDR;

  // Tracks whether a run has started and its last write is not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      run_open_q <= !last_o;
    end
  end

  // A stalled write stays on the bus unchanged.
  `TLCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_word))

  // New bytes are held off while a run is still being emitted.
  `TLCD_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, out_more, in_stall_o)

  // Every run opens with the clear command.
  `TLCD_ASSERT_IMP(a_run_head, clk_i, rst_ni, run_first, is_clear_cmd)

  // A command that ends a run is the bottom-row set-address.
  `TLCD_ASSERT_IMP(a_last_cmd, clk_i, rst_ni, last_cmd, is_addr_cmd)

endmodule

bind text_line_to_char_lcd_writer tlcd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .is_data_o   (is_data_o),
  .bus_byte_o  (bus_byte_o),
  .last_o      (last_o)
);
